// ===== rtl/core/pid_pkg.sv =====
// Package for the pairwise identity distance block: sizes, codes, state
// encoding and the row memory entry type. No dependencies.
`timescale 1ns / 1ps

package pid_pkg;

    // Storage sizes
    localparam int MAX_LEN   = 1024;
    localparam int ALPHABET  = 32;
    localparam int ADDR_W    = $clog2(MAX_LEN);
    localparam int LEN_W     = $clog2(MAX_LEN + 1);
    localparam int TBL_DEPTH = ALPHABET * ALPHABET;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);

    // Field widths
    localparam int ACT_W    = 2;
    localparam int CODE_W   = 5;
    localparam int ANCHOR_W = 16;
    localparam int TSC_W    = 16;
    localparam int GAP_W    = 16;
    localparam int SCORE_W  = 32;
    localparam int FRAC_W   = 16;
    localparam int DIST_W   = FRAC_W + 1;
    localparam int IDENT_W  = 11;
    localparam int STAT_W   = 2;
    localparam int CFG_IW   = 1;

    // Divider sizes
    localparam int NUM_W = LEN_W + FRAC_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    // Item actions
    typedef enum logic [ACT_W-1:0] {
        ACT_TABLE    = 2'd0,
        ACT_APPEND_A = 2'd1,
        ACT_APPEND_B = 2'd2,
        ACT_COMPUTE  = 2'd3
    } t_action;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_GAP_OPEN   = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_GAP_EXTEND = 1'b1;

    // Sequencer states
    typedef enum logic [17:0] {
        S_IDLE      = 18'h00001,
        S_OUTER     = 18'h00002,
        S_ANCH      = 18'h00004,
        S_SCAN      = 18'h00008,
        S_SCAN_D    = 18'h00010,
        S_WA        = 18'h00020,
        S_WA_D      = 18'h00040,
        S_WB        = 18'h00080,
        S_WB_D      = 18'h00100,
        S_ROW       = 18'h00200,
        S_ROW_D     = 18'h00400,
        S_CELL_ADDR = 18'h00800,
        S_CELL_TBL  = 18'h01000,
        S_CELL_SUM  = 18'h02000,
        S_CELL_PICK = 18'h04000,
        S_CELL_WR   = 18'h08000,
        S_DIV       = 18'h10000,
        S_DONE      = 18'h20000
    } t_state;

    // One stored residue
    typedef struct packed {
        logic [CODE_W-1:0]          code;
        logic signed [ANCHOR_W-1:0] anchor;
    } t_residue;

    // One entry of the previous DP row
    typedef struct packed {
        logic signed [SCORE_W-1:0] best;
        logic signed [SCORE_W-1:0] gapx;
        logic [LEN_W-1:0]          ident;
    } t_row_entry;

    // Flat index of a substitution table entry
    function automatic logic [TBL_AW-1:0] tbl_index(input logic [CODE_W-1:0] row,
                                                    input logic [CODE_W-1:0] col);
        tbl_index = TBL_AW'(32'(row) * ALPHABET + 32'(col));
    endfunction

endpackage

// ===== rtl/core/pairwise_identity_distance.sv =====
// Pairwise identity distance top level: sequence, table and row memories
// and the shared cell datapath under one sequencer. Depends on pid_pkg.
`timescale 1ns / 1ps

// Load items (table entry, append to A, append to B) are taken one per cycle
// and give no result. A compute item holds the input stalled until its result
// is registered. With an overflowed or empty sequence it only sets that status;
// else it walks the anchor segments (one memory read per scan step), then every
// matrix cell of each segment, paced by the single shared cell datapath and the
// registered reads of the sequence, table and row memories, and ends with a
// bit-serial divide. Stores need no clearing pass after reset.
// The result waits in an output register while new load items are accepted.
module pairwise_identity_distance (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [pid_pkg::ACT_W-1:0]           i_action,
    input  logic [pid_pkg::CODE_W-1:0]          i_code_row,
    input  logic [pid_pkg::CODE_W-1:0]          i_code_col,
    input  logic signed [pid_pkg::ANCHOR_W-1:0] i_anchor,
    input  logic signed [pid_pkg::TSC_W-1:0]    i_table_score,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [pid_pkg::DIST_W-1:0]          o_distance,
    output logic [pid_pkg::IDENT_W-1:0]         o_identity_count,
    output logic [pid_pkg::STAT_W-1:0]          o_status,
    input  logic                                i_cfg_we,
    input  logic [pid_pkg::CFG_IW-1:0]          i_cfg_index,
    input  logic [pid_pkg::GAP_W-1:0]           i_cfg_data
);
    import pid_pkg::*;

    // Memories
    t_residue                mem_a   [MAX_LEN];
    t_residue                mem_b   [MAX_LEN];
    logic signed [TSC_W-1:0] mem_tbl [TBL_DEPTH];
    t_row_entry              mem_row [MAX_LEN];

    t_residue                r_a_q;
    t_residue                r_b_q;
    logic signed [TSC_W-1:0] r_tbl_q;
    t_row_entry              r_row_q;

    logic [ADDR_W-1:0] a_addr;
    logic [ADDR_W-1:0] b_addr;
    logic [TBL_AW-1:0] tbl_raddr;

    // Control
    t_state           r_state;
    logic [GAP_W-1:0] r_gap_open;
    logic [GAP_W-1:0] r_gap_extend;
    logic [LEN_W-1:0] r_len_a;
    logic [LEN_W-1:0] r_len_b;
    logic             r_ovf;
    logic [LEN_W-1:0] r_x;
    logic [LEN_W-1:0] r_y;
    logic [LEN_W-1:0] r_ex;
    logic [LEN_W-1:0] r_ey;
    logic [LEN_W-1:0] r_yc;
    logic [LEN_W-1:0] r_total;
    logic             r_row_first;
    logic             r_col_first;
    logic             r_have;
    logic             r_out_valid;

    // Cell datapath
    logic [CODE_W-1:0]         r_ra;
    logic                      r_code_ok;
    logic signed [SCORE_W-1:0] r_diag_b;
    logic signed [SCORE_W-1:0] r_iy;
    logic [LEN_W-1:0]          r_diag_i;
    logic [LEN_W-1:0]          r_left_i;
    logic signed [SCORE_W-1:0] r_m;
    logic signed [SCORE_W-1:0] r_ix1;
    logic signed [SCORE_W-1:0] r_iy1;
    logic                      r_eq;
    logic signed [SCORE_W-1:0] r_s;
    logic [LEN_W-1:0]          r_i;
    logic signed [SCORE_W-1:0] r_mg;
    logic signed [SCORE_W-1:0] r_ixg;
    logic signed [SCORE_W-1:0] r_iyg;
    logic signed [SCORE_W-1:0] r_high;
    logic [LEN_W-1:0]          r_high_id;

    // Divider and result
    logic [NUM_W-1:0]  r_num;
    logic [LEN_W-1:0]  r_rem;
    logic [LEN_W-1:0]  r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic [LEN_W-1:0]  r_res_id;
    logic [STAT_W-1:0] r_res_status;
    logic [DIST_W-1:0]   r_dist;
    logic [IDENT_W-1:0]  r_ident;
    logic [STAT_W-1:0]   r_status;

    // Combinational helpers
    logic                      in_acc;
    logic signed [SCORE_W-1:0] n_gapx;
    logic signed [SCORE_W-1:0] n_iy;
    logic                      n_edge;
    logic [LEN_W-1:0]          n_l;
    logic [LEN_W-1:0]          n_id;
    logic [LEN_W:0]            n_rem2;
    logic                      n_qbit;
    logic signed [SCORE_W-1:0] go_ext;
    logic signed [SCORE_W-1:0] ge_ext;
    logic signed [SCORE_W-1:0] tsc_ext;
    logic                      pick_diag;
    logic                      pick_up;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_distance       = r_dist;
    assign o_identity_count = r_ident;
    assign o_status         = r_status;

    assign go_ext  = SCORE_W'({1'b0, r_gap_open});
    assign ge_ext  = SCORE_W'({1'b0, r_gap_extend});
    assign tsc_ext = r_code_ok ? SCORE_W'(r_tbl_q) : '0;

    // Pick memory read addresses by state
    always_comb begin
        a_addr    = r_ex[ADDR_W-1:0];
        b_addr    = r_ey[ADDR_W-1:0];
        tbl_raddr = tbl_index(r_ra, r_b_q.code);
        if (r_state == S_OUTER || r_state == S_ROW) begin
            a_addr = r_x[ADDR_W-1:0];
        end
        if (r_state == S_OUTER) begin
            b_addr = r_y[ADDR_W-1:0];
        end else if (r_state == S_CELL_ADDR) begin
            b_addr = r_yc[ADDR_W-1:0];
        end
    end

    // Finish one cell: gap terms and edge test
    always_comb begin
        n_gapx = (r_mg > r_ixg) ? r_mg : r_ixg;
        n_iy   = (r_mg > r_iyg) ? r_mg : r_iyg;
        n_edge = (LEN_W'(r_x + 1'b1) == r_ex) || (LEN_W'(r_yc + 1'b1) == r_ey);
    end

    // Choose the cell's source, diagonal first
    assign pick_diag = (r_m >= r_ix1) && (r_m >= r_iy1);
    assign pick_up   = (r_ix1 >= r_iy1);

    // Clamp the identity count and run one divide step
    always_comb begin
        n_l    = (r_len_a > r_len_b) ? r_len_a : r_len_b;
        n_id   = (r_total > n_l) ? n_l : r_total;
        n_rem2 = {r_rem, r_num[NUM_W-1]};
        n_qbit = (n_rem2 >= {1'b0, r_div});
    end

    // Memory ports
    always_ff @(posedge i_clk) begin
        r_a_q   <= mem_a[a_addr];
        r_b_q   <= mem_b[b_addr];
        r_tbl_q <= mem_tbl[tbl_raddr];
        r_row_q <= mem_row[r_yc[ADDR_W-1:0]];
        if (in_acc && t_action'(i_action) == ACT_TABLE &&
                32'(i_code_row) < ALPHABET && 32'(i_code_col) < ALPHABET) begin
            mem_tbl[tbl_index(i_code_row, i_code_col)] <= i_table_score;
        end
        if (in_acc && t_action'(i_action) == ACT_APPEND_A && 32'(r_len_a) < MAX_LEN) begin
            mem_a[r_len_a[ADDR_W-1:0]] <= '{code: i_code_row, anchor: i_anchor};
        end
        if (in_acc && t_action'(i_action) == ACT_APPEND_B && 32'(r_len_b) < MAX_LEN) begin
            mem_b[r_len_b[ADDR_W-1:0]] <= '{code: i_code_row, anchor: i_anchor};
        end
        if (r_state == S_CELL_WR) begin
            mem_row[r_yc[ADDR_W-1:0]] <= '{best: r_s, gapx: n_gapx, ident: r_i};
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_gap_open   <= GAP_W'(2560);
            r_gap_extend <= GAP_W'(51);
            r_len_a      <= '0;
            r_len_b      <= '0;
            r_ovf        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_have       <= 1'b0;
            r_row_first  <= 1'b0;
            r_col_first  <= 1'b0;
        end else begin
            // Register writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_GAP_OPEN:   r_gap_open   <= i_cfg_data;
                    CFG_GAP_EXTEND: r_gap_extend <= i_cfg_data;
                    default: ;
                endcase
            end

            // Drop the result once taken; the hand-over state loads the next one
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (t_action'(i_action))
                            ACT_APPEND_A: begin
                                if (32'(r_len_a) < MAX_LEN) begin
                                    r_len_a <= LEN_W'(r_len_a + 1'b1);
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                            ACT_APPEND_B: begin
                                if (32'(r_len_b) < MAX_LEN) begin
                                    r_len_b <= LEN_W'(r_len_b + 1'b1);
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                            ACT_COMPUTE: begin
                                r_num    <= NUM_W'(1) << FRAC_W;
                                r_res_id <= '0;
                                if (r_ovf) begin
                                    r_res_status <= ST_OVERFLOW;
                                    r_state      <= S_DONE;
                                end else if (r_len_a == '0 || r_len_b == '0) begin
                                    r_res_status <= ST_EMPTY;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_res_status <= ST_OK;
                                    r_x     <= '0;
                                    r_y     <= '0;
                                    r_ex    <= '0;
                                    r_ey    <= '0;
                                    r_total <= '0;
                                    r_state <= S_OUTER;
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                // Outer loop: test bounds, read residues at x and y
                S_OUTER: begin
                    if (r_x < r_len_a && r_y < r_len_b) begin
                        r_state <= S_ANCH;
                    end else begin
                        r_res_id <= n_id;
                        r_num    <= NUM_W'({(n_l - n_id), FRAC_W'(0)}) +
                                    NUM_W'(n_l >> 1);
                        r_div    <= n_l;
                        r_rem    <= '0;
                        r_cnt    <= CNT_W'(NUM_W);
                        r_state  <= S_DIV;
                    end
                end

                // Forced match on equal nonzero anchors
                S_ANCH: begin
                    if (r_x == r_ex && r_y == r_ey && r_a_q.anchor == r_b_q.anchor &&
                            r_a_q.anchor != '0) begin
                        r_total <= LEN_W'(r_total + LEN_W'(r_a_q.code == r_b_q.code));
                        r_x     <= LEN_W'(r_x + 1'b1);
                        r_ex    <= LEN_W'(r_ex + 1'b1);
                        r_y     <= LEN_W'(r_y + 1'b1);
                        r_ey    <= LEN_W'(r_ey + 1'b1);
                        r_state <= S_OUTER;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end

                // Segment end search
                S_SCAN: begin
                    if (r_ex < r_len_a || r_ey < r_len_b) begin
                        r_state <= S_SCAN_D;
                    end else begin
                        r_state <= S_ROW;
                    end
                end

                S_SCAN_D: begin
                    if (r_ex < r_len_a && r_a_q.anchor == '0) begin
                        r_ex    <= LEN_W'(r_ex + 1'b1);
                        r_state <= S_SCAN;
                    end else if (r_ey < r_len_b && r_b_q.anchor == '0) begin
                        r_ey    <= LEN_W'(r_ey + 1'b1);
                        r_state <= S_SCAN;
                    end else if (r_ex < r_len_a && r_ey < r_len_b &&
                                 r_a_q.anchor == r_b_q.anchor) begin
                        r_state <= S_ROW;
                    end else begin
                        r_state <= S_WA;
                    end
                end

                // Advance ex past smaller anchors
                S_WA: begin
                    r_state <= (r_ex < r_len_a) ? S_WA_D : S_WB;
                end

                S_WA_D: begin
                    if (r_ey == r_len_b || r_a_q.anchor < r_b_q.anchor) begin
                        r_ex    <= LEN_W'(r_ex + 1'b1);
                        r_state <= S_WA;
                    end else begin
                        r_state <= S_WB;
                    end
                end

                // Advance ey past smaller anchors
                S_WB: begin
                    r_state <= (r_ey < r_len_b) ? S_WB_D : S_ROW;
                end

                S_WB_D: begin
                    if (r_ex == r_len_a || r_b_q.anchor < r_a_q.anchor) begin
                        r_ey    <= LEN_W'(r_ey + 1'b1);
                        r_state <= S_WB;
                    end else if (r_ex < r_len_a && r_a_q.anchor != r_b_q.anchor) begin
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_ROW;
                    end
                end

                // Row loop of a segment
                S_ROW: begin
                    if (r_x == r_ex) begin
                        if (r_have) begin
                            r_total <= LEN_W'(r_total + r_high_id);
                        end
                        r_have      <= 1'b0;
                        r_row_first <= 1'b1;
                        r_y         <= r_ey;
                        r_state     <= S_OUTER;
                    end else begin
                        r_state <= S_ROW_D;
                    end
                end

                S_ROW_D: begin
                    r_ra        <= r_a_q.code;
                    r_yc        <= r_y;
                    r_col_first <= 1'b1;
                    r_diag_b    <= '0;
                    r_iy        <= '0;
                    r_diag_i    <= '0;
                    r_left_i    <= '0;
                    r_state     <= S_CELL_ADDR;
                end

                // Cell loop: read column residue and row entry
                S_CELL_ADDR: begin
                    if (r_yc == r_ey) begin
                        r_x         <= LEN_W'(r_x + 1'b1);
                        r_row_first <= 1'b0;
                        r_state     <= S_ROW;
                    end else begin
                        r_state <= S_CELL_TBL;
                    end
                end

                // Look up the substitution score
                S_CELL_TBL: begin
                    r_code_ok <= (32'(r_ra) < ALPHABET) && (32'(r_b_q.code) < ALPHABET);
                    r_eq      <= (r_ra == r_b_q.code);
                    r_state   <= S_CELL_SUM;
                end

                // Match score and gap inputs
                S_CELL_SUM: begin
                    r_m     <= tsc_ext + ((!r_row_first && !r_col_first) ? r_diag_b : '0);
                    r_ix1   <= r_row_first ? '0 : r_row_q.gapx;
                    r_iy1   <= r_col_first ? '0 : r_iy;
                    r_state <= S_CELL_PICK;
                end

                // Select the best source and its identity count
                S_CELL_PICK: begin
                    if (pick_diag) begin
                        r_s <= r_m;
                        r_i <= LEN_W'(r_eq) +
                               ((!r_row_first && !r_col_first) ? r_diag_i : '0);
                    end else if (pick_up) begin
                        r_s <= r_ix1;
                        r_i <= LEN_W'(r_eq) + (r_row_first ? '0 : r_row_q.ident);
                    end else begin
                        r_s <= r_iy1;
                        r_i <= LEN_W'(r_eq) + (r_col_first ? '0 : r_left_i);
                    end
                    r_mg    <= r_m - go_ext;
                    r_ixg   <= r_ix1 - ge_ext;
                    r_iyg   <= r_iy1 - ge_ext;
                    r_state <= S_CELL_WR;
                end

                // Store the cell, track the best edge cell
                S_CELL_WR: begin
                    if (n_edge && (!r_have || r_high < r_s)) begin
                        r_have    <= 1'b1;
                        r_high    <= r_s;
                        r_high_id <= r_i;
                    end
                    r_iy        <= n_iy;
                    r_left_i    <= r_i;
                    r_diag_b    <= r_row_q.best;
                    r_diag_i    <= r_row_q.ident;
                    r_col_first <= 1'b0;
                    r_yc        <= LEN_W'(r_yc + 1'b1);
                    r_state     <= S_CELL_ADDR;
                end

                // Restoring divide, one quotient bit a cycle
                S_DIV: begin
                    r_rem   <= n_qbit ? LEN_W'(n_rem2 - {1'b0, r_div}) : LEN_W'(n_rem2);
                    r_num   <= {r_num[NUM_W-2:0], n_qbit};
                    r_cnt   <= CNT_W'(r_cnt - 1'b1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_DONE;
                    end
                end

                // Hand over the result and clear the sequences
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_dist      <= r_num[DIST_W-1:0];
                        r_ident     <= IDENT_W'(r_res_id);
                        r_status    <= r_res_status;
                        r_len_a     <= '0;
                        r_len_b     <= '0;
                        r_ovf       <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase

            // Segment setup on entry to the row loop
            if ((r_state == S_SCAN && !(r_ex < r_len_a || r_ey < r_len_b)) ||
                    (r_state == S_SCAN_D && !(r_ex < r_len_a && r_a_q.anchor == '0) &&
                     !(r_ey < r_len_b && r_b_q.anchor == '0) &&
                     r_ex < r_len_a && r_ey < r_len_b &&
                     r_a_q.anchor == r_b_q.anchor) ||
                    (r_state == S_WB && !(r_ey < r_len_b)) ||
                    (r_state == S_WB_D && !(r_ex == r_len_a || r_b_q.anchor < r_a_q.anchor) &&
                     !(r_ex < r_len_a && r_a_q.anchor != r_b_q.anchor))) begin
                r_have      <= 1'b0;
                r_row_first <= 1'b1;
                r_high_id   <= '0;
                r_high      <= '0;
            end
        end
    end

`ifndef SYNTH
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_len_a) <= MAX_LEN && 32'(r_len_b) <= MAX_LEN)
        else $error("sequence length beyond capacity");

    a_seg_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_DONE && r_state != S_DIV) |->
        (r_x <= r_ex && r_ex <= r_len_a && r_y <= r_ey && r_ey <= r_len_b))
        else $error("segment bounds out of order");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CELL_TBL) |-> (r_yc >= r_y && r_yc < r_ey && r_x < r_ex))
        else $error("cell outside its segment");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt != '0))
        else $error("divider ran past its last step");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !(r_out_valid && i_out_stall)) |=>
        (r_out_valid && r_len_a == '0 && r_len_b == '0 && !r_ovf))
        else $error("result handed over without clearing sequences");
`endif

endmodule
